// ----- rtl/psq_pkg.sv -----
// shared types, constants and helpers of the priority send queue
package psq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RM_W = 5;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int RUN_MAX = 15;

    localparam logic [2:0] CMD_ENQ = 3'd0;
    localparam logic [2:0] CMD_DRAIN = 3'd1;
    localparam logic [2:0] CMD_CLR_LOW = 3'd2;
    localparam logic [2:0] CMD_CLR_ALL = 3'd3;
    localparam logic [2:0] CMD_PURGE = 3'd4;

    localparam logic [1:0] KIND_SENT = 2'd0;
    localparam logic [1:0] KIND_ACK = 2'd1;
    localparam logic [1:0] KIND_WAIT = 2'd2;

    localparam logic [2:0] REG_OFFSET = 3'd0;
    localparam logic [2:0] REG_LOW_LIMIT = 3'd1;
    localparam logic [2:0] REG_CAP = 3'd2;
    localparam logic [2:0] REG_COST = 3'd3;
    localparam logic [2:0] REG_IDLE_WAIT = 3'd4;

    localparam logic [7:0] WAIT_NO_CREDIT = 8'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [10:0] base_priority;
        logic [15:0] payload_handle;
        logic [15:0] dest_key;
        logic        is_notice;
        logic [7:0]  elapsed_seconds;
    } t_in_word;

    typedef struct packed {
        logic [1:0]      kind;
        logic [15:0]     sent_handle;
        logic [7:0]      wait_seconds;
        logic            queue_full;
        logic [RM_W-1:0] removed_count;
        logic            last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [10:0] priority_offset;
        logic [11:0] low_priority_limit;
        logic [3:0]  credit_cap;
        logic [3:0]  credit_cost;
        logic [7:0]  idle_wait_seconds;
    } t_cfg;

    typedef struct packed {
        logic [11:0] prio;
        logic [15:0] handle;
        logic [15:0] dest;
        logic        notice;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_DR_CHK,
        ST_DR_SEND,
        ST_CL_RD,
        ST_CL_CHK,
        ST_PG_RD,
        ST_PG_CHK,
        ST_EMIT
    } t_state;

    // logical queue position to physical slot, circular from the head
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = (IDX_W + 1)'(head) + (IDX_W + 1)'(pos);
        if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/psq_in_if.sv -----
// command channel interface
interface psq_in_if;
    logic               valid;
    logic               ready;
    psq_pkg::t_in_word  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/psq_out_if.sv -----
// result channel interface
interface psq_out_if;
    logic               valid;
    logic               ready;
    psq_pkg::t_out_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/psq_cfg.sv -----
// apb configuration registers
module psq_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psq_pkg::APB_AW-1:0]  paddr,
    input  logic [psq_pkg::APB_DW-1:0]  pwdata,
    output logic [psq_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output psq_pkg::t_cfg               o_cfg
);
    psq_pkg::t_cfg r_cfg;
    logic [2:0]    idx;

    assign idx = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.priority_offset <= 11'd0;
            r_cfg.low_priority_limit <= 12'd200;
            r_cfg.credit_cap <= 4'd9;
            r_cfg.credit_cost <= 4'd2;
            r_cfg.idle_wait_seconds <= 8'd30;
        end else if (psel && penable && pwrite) begin
            case (idx)
                psq_pkg::REG_OFFSET:    r_cfg.priority_offset <= pwdata[10:0];
                psq_pkg::REG_LOW_LIMIT: r_cfg.low_priority_limit <= pwdata[11:0];
                psq_pkg::REG_CAP:       r_cfg.credit_cap <= pwdata[3:0];
                psq_pkg::REG_COST:      r_cfg.credit_cost <= pwdata[3:0];
                psq_pkg::REG_IDLE_WAIT: r_cfg.idle_wait_seconds <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            psq_pkg::REG_OFFSET:    prdata = 32'(r_cfg.priority_offset);
            psq_pkg::REG_LOW_LIMIT: prdata = 32'(r_cfg.low_priority_limit);
            psq_pkg::REG_CAP:       prdata = 32'(r_cfg.credit_cap);
            psq_pkg::REG_COST:      prdata = 32'(r_cfg.credit_cost);
            psq_pkg::REG_IDLE_WAIT: prdata = 32'(r_cfg.idle_wait_seconds);
            default:                prdata = '0;
        endcase
    end
endmodule

// ----- rtl/psq_mem.sv -----
// entry store, one write and one registered read port
module psq_mem (
    input  logic                i_clk,
    input  psq_pkg::t_mem_req   i_req,
    output psq_pkg::t_entry     o_rdata
);
    psq_pkg::t_entry r_mem [psq_pkg::QUEUE_DEPTH];
    psq_pkg::t_entry r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end
endmodule

// ----- rtl/priority_send_queue_with_credit_unit.sv -----
// top level: sorted send queue with credit-limited drain
// enqueue shifts each entry below the new one up a slot, walking from the tail; a full
// queue only answers; drain sends one word per entry while credit lasts, then a wait word;
// clear-low reads from the head up to the first low entry, purge reads every entry;
// clear all and unknown commands go straight to the result word; one command at a time
// reset: synchronous active low, empties the queue and zeroes the send credit
module priority_send_queue_with_credit_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    psq_in_if.sink                      i_req,
    psq_out_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psq_pkg::APB_AW-1:0]  paddr,
    input  logic [psq_pkg::APB_DW-1:0]  pwdata,
    output logic [psq_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    localparam int IW = psq_pkg::IDX_W;
    localparam int CW = psq_pkg::CNT_W;

    psq_pkg::t_cfg      cfg;
    psq_pkg::t_mem_req  mem;
    psq_pkg::t_entry    rdata;

    // control state
    psq_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_head, n_head;
    logic [4:0]         r_credit, n_credit;     // two's complement
    logic               r_ov, n_ov;
    // working registers
    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic [3:0]         r_n, n_n;               // words sent in this drain
    psq_pkg::t_in_word  r_item, n_item;
    logic [11:0]        r_prio, n_prio;
    psq_pkg::t_out_word r_res, n_res;
    psq_pkg::t_out_word r_out, n_out;

    logic               accept;
    logic               can_emit;
    logic               no_credit;
    logic               full;
    logic               ins_here;
    logic               purge_hit;
    logic signed [9:0]  credit_sum;
    logic [4:0]         cost;
    psq_pkg::t_entry    new_entry;

    psq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    psq_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem),
        .o_rdata (rdata)
    );

    assign i_req.ready = (r_state == psq_pkg::ST_IDLE);
    assign accept = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data = r_out;
    // output register free now or freed at this edge
    assign can_emit = !r_ov || o_rsp.ready;

    assign full = (r_count >= CW'(psq_pkg::QUEUE_DEPTH));
    assign no_credit = r_credit[4] || (r_credit == 5'd0) || (r_n >= 4'(psq_pkg::RUN_MAX));
    assign ins_here = (r_prio <= rdata.prio);
    assign purge_hit = rdata.notice && (rdata.dest == r_item.dest_key);
    assign credit_sum = 10'(signed'(r_credit)) + signed'({2'b00, i_req.data.elapsed_seconds});
    assign cost = (cfg.credit_cost == 4'd0) ? 5'd1 : {1'b0, cfg.credit_cost};
    assign new_entry = '{prio: r_prio, handle: r_item.payload_handle,
                         dest: r_item.dest_key, notice: r_item.is_notice};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            psq_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_req.data.command)
                        psq_pkg::CMD_ENQ:
                            n_state = full ? psq_pkg::ST_EMIT : psq_pkg::ST_INS_RD;
                        psq_pkg::CMD_DRAIN:
                            n_state = (r_count == '0) ? psq_pkg::ST_EMIT
                                                      : psq_pkg::ST_DR_CHK;
                        psq_pkg::CMD_CLR_LOW: n_state = psq_pkg::ST_CL_RD;
                        psq_pkg::CMD_PURGE:   n_state = psq_pkg::ST_PG_RD;
                        default:              n_state = psq_pkg::ST_EMIT;
                    endcase
                end
            end
            psq_pkg::ST_INS_RD:
                n_state = (r_j == '0) ? psq_pkg::ST_EMIT : psq_pkg::ST_INS_CHK;
            psq_pkg::ST_INS_CHK:
                n_state = ins_here ? psq_pkg::ST_EMIT : psq_pkg::ST_INS_RD;
            psq_pkg::ST_DR_CHK:
                n_state = ((r_count == '0) || no_credit) ? psq_pkg::ST_EMIT
                                                         : psq_pkg::ST_DR_SEND;
            psq_pkg::ST_DR_SEND:
                if (can_emit) begin
                    n_state = psq_pkg::ST_DR_CHK;
                end
            psq_pkg::ST_CL_RD:
                n_state = (r_i == r_count) ? psq_pkg::ST_EMIT : psq_pkg::ST_CL_CHK;
            psq_pkg::ST_CL_CHK:
                n_state = (rdata.prio > cfg.low_priority_limit) ? psq_pkg::ST_CL_RD
                                                                : psq_pkg::ST_EMIT;
            psq_pkg::ST_PG_RD:
                n_state = (r_i == r_count) ? psq_pkg::ST_EMIT : psq_pkg::ST_PG_CHK;
            psq_pkg::ST_PG_CHK: n_state = psq_pkg::ST_PG_RD;
            psq_pkg::ST_EMIT:
                if (can_emit) begin
                    n_state = psq_pkg::ST_IDLE;
                end
            default: n_state = psq_pkg::ST_IDLE;
        endcase
    end

    // datapath, store accesses and result words
    always_comb begin
        n_count = r_count;
        n_head = r_head;
        n_credit = r_credit;
        n_i = r_i;
        n_j = r_j;
        n_n = r_n;
        n_item = r_item;
        n_prio = r_prio;
        n_res = r_res;
        n_out = r_out;
        n_ov = r_ov && !o_rsp.ready;
        mem = '0;

        case (r_state)
            psq_pkg::ST_IDLE: begin
                if (accept) begin
                    n_item = i_req.data;
                    n_prio = 12'(i_req.data.base_priority) + 12'(cfg.priority_offset);
                    n_i = '0;
                    n_j = r_count;
                    n_n = '0;
                    n_res = '0;
                    n_res.last_of_run = 1'b1;
                    n_res.kind = psq_pkg::KIND_ACK;
                    case (i_req.data.command)
                        psq_pkg::CMD_ENQ: n_res.queue_full = full;
                        psq_pkg::CMD_DRAIN: begin
                            if (r_count == '0) begin
                                n_res.kind = psq_pkg::KIND_WAIT;
                                n_res.wait_seconds = cfg.idle_wait_seconds;
                            end else if (credit_sum > signed'(10'(cfg.credit_cap))) begin
                                n_credit = {1'b0, cfg.credit_cap};
                            end else begin
                                n_credit = credit_sum[4:0];
                            end
                        end
                        psq_pkg::CMD_CLR_ALL: begin
                            n_res.removed_count = psq_pkg::RM_W'(r_count);
                            n_count = '0;
                        end
                        // survivors are compacted from the head
                        psq_pkg::CMD_PURGE: n_j = '0;
                        default: begin
                        end
                    endcase
                end
            end
            psq_pkg::ST_INS_RD: begin
                if (r_j == '0) begin
                    mem.we = 1'b1;
                    mem.waddr = psq_pkg::phys(r_head, '0);
                    mem.wdata = new_entry;
                    n_count = r_count + 1'b1;
                end else begin
                    mem.re = 1'b1;
                    mem.raddr = psq_pkg::phys(r_head, r_j - 1'b1);
                end
            end
            psq_pkg::ST_INS_CHK: begin
                // shift the entry above up one slot, or drop the new one in
                mem.we = 1'b1;
                mem.waddr = psq_pkg::phys(r_head, r_j);
                if (ins_here) begin
                    mem.wdata = new_entry;
                    n_count = r_count + 1'b1;
                end else begin
                    mem.wdata = rdata;
                    n_j = r_j - 1'b1;
                end
            end
            psq_pkg::ST_DR_CHK: begin
                n_res = '0;
                n_res.last_of_run = 1'b1;
                n_res.kind = psq_pkg::KIND_WAIT;
                if (r_count == '0) begin
                    n_res.wait_seconds = cfg.idle_wait_seconds;
                end else if (no_credit) begin
                    n_res.wait_seconds = psq_pkg::WAIT_NO_CREDIT;
                end else begin
                    mem.re = 1'b1;
                    mem.raddr = r_head;
                end
            end
            psq_pkg::ST_DR_SEND: begin
                if (can_emit) begin
                    n_out = '0;
                    n_out.kind = psq_pkg::KIND_SENT;
                    n_out.sent_handle = rdata.handle;
                    n_ov = 1'b1;
                    n_credit = r_credit - cost;
                    n_head = psq_pkg::phys(r_head, CW'(1));
                    n_count = r_count - 1'b1;
                    n_n = r_n + 1'b1;
                end
            end
            psq_pkg::ST_CL_RD: begin
                if (r_i == r_count) begin
                    n_res.removed_count = '0;
                end else begin
                    mem.re = 1'b1;
                    mem.raddr = psq_pkg::phys(r_head, r_i);
                end
            end
            psq_pkg::ST_CL_CHK: begin
                // sorted, so everything from the first low entry on goes
                if (rdata.prio > cfg.low_priority_limit) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_res.removed_count = psq_pkg::RM_W'(r_count - r_i);
                    n_count = r_i;
                end
            end
            psq_pkg::ST_PG_RD: begin
                if (r_i == r_count) begin
                    n_res.removed_count = psq_pkg::RM_W'(r_count - r_j);
                    n_count = r_j;
                end else begin
                    mem.re = 1'b1;
                    mem.raddr = psq_pkg::phys(r_head, r_i);
                end
            end
            psq_pkg::ST_PG_CHK: begin
                // compact survivors toward the head, order kept
                if (!purge_hit) begin
                    mem.we = 1'b1;
                    mem.waddr = psq_pkg::phys(r_head, r_j);
                    mem.wdata = rdata;
                    n_j = r_j + 1'b1;
                end
                n_i = r_i + 1'b1;
            end
            psq_pkg::ST_EMIT: begin
                if (can_emit) begin
                    n_out = r_res;
                    n_ov = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psq_pkg::ST_IDLE;
            r_count <= '0;
            r_head <= '0;
            r_credit <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head <= n_head;
            r_credit <= n_credit;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_n <= n_n;
        r_item <= n_item;
        r_prio <= n_prio;
        r_res <= n_res;
        r_out <= n_out;
    end

    // fill level stays within the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(psq_pkg::QUEUE_DEPTH))
        else $error("queue fill level beyond depth");

    // an insert walk only runs on a queue with a free slot
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psq_pkg::ST_INS_CHK) |-> (r_count < CW'(psq_pkg::QUEUE_DEPTH)))
        else $error("insert walk on a full queue");

    // each sent word removes exactly one entry
    a_send_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psq_pkg::ST_DR_SEND && can_emit) |=>
        (r_count == $past(r_count) - 1'b1))
        else $error("sent word without matching pop");

    // store never written and read at the same slot in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem.we && mem.re) |-> (mem.waddr != mem.raddr))
        else $error("same-slot read and write");

endmodule

// ----- bench/tb_psq_scoreboard.sv -----
// scoreboard class: predicts result words of the send queue and checks them
class psq_scoreboard;
    typedef struct {
        logic [11:0] prio;
        logic [15:0] handle;
        logic [15:0] dest;
        logic        notice;
    } t_queue_slot;

    t_queue_slot slots[$];
    int          credit;
    psq_pkg::t_cfg cfg;
    psq_pkg::t_out_word pending_words[$];
    int          fail_count;

    function new();
        credit = 0;
        fail_count = 0;
        cfg.priority_offset = 11'd0;
        cfg.low_priority_limit = 12'd200;
        cfg.credit_cap = 4'd9;
        cfg.credit_cost = 4'd2;
        cfg.idle_wait_seconds = 8'd30;
    endfunction

    function void push_word(logic [1:0] kind, logic [15:0] handle, logic [7:0] wait_s,
                            logic full, logic [4:0] removed, logic last);
        psq_pkg::t_out_word w;
        w.kind = kind;
        w.sent_handle = handle;
        w.wait_seconds = wait_s;
        w.queue_full = full;
        w.removed_count = removed;
        w.last_of_run = last;
        pending_words.push_back(w);
    endfunction

    // work out every result word that one accepted command causes
    function void note_command(psq_pkg::t_in_word c);
        t_queue_slot s;
        t_queue_slot kept[$];
        int pos;
        int cost;
        int sent;
        int removed;
        case (c.command)
            psq_pkg::CMD_ENQ: begin
                if (slots.size() >= psq_pkg::QUEUE_DEPTH) begin
                    push_word(psq_pkg::KIND_ACK, 0, 0, 1'b1, 0, 1'b1);
                end else begin
                    s.prio = 12'(c.base_priority) + 12'(cfg.priority_offset);
                    s.handle = c.payload_handle;
                    s.dest = c.dest_key;
                    s.notice = c.is_notice;
                    pos = 0;
                    while (pos < slots.size() && s.prio <= slots[pos].prio) pos++;
                    slots.insert(pos, s);
                    push_word(psq_pkg::KIND_ACK, 0, 0, 1'b0, 0, 1'b1);
                end
            end
            psq_pkg::CMD_DRAIN: begin
                cost = (cfg.credit_cost == 0) ? 1 : int'(cfg.credit_cost);
                sent = 0;
                if (slots.size() == 0) begin
                    push_word(psq_pkg::KIND_WAIT, 0, cfg.idle_wait_seconds, 0, 0, 1'b1);
                end else begin
                    credit = credit + int'(c.elapsed_seconds);
                    if (credit > int'(cfg.credit_cap)) credit = int'(cfg.credit_cap);
                    forever begin
                        if (slots.size() == 0) begin
                            push_word(psq_pkg::KIND_WAIT, 0, cfg.idle_wait_seconds,
                                      0, 0, 1'b1);
                            break;
                        end
                        if (credit < 1 || sent >= psq_pkg::RUN_MAX) begin
                            push_word(psq_pkg::KIND_WAIT, 0, psq_pkg::WAIT_NO_CREDIT,
                                      0, 0, 1'b1);
                            break;
                        end
                        credit = credit - cost;
                        push_word(psq_pkg::KIND_SENT, slots[0].handle, 0, 0, 0, 1'b0);
                        void'(slots.pop_front());
                        sent++;
                    end
                end
            end
            psq_pkg::CMD_CLR_LOW: begin
                pos = 0;
                while (pos < slots.size() && slots[pos].prio > cfg.low_priority_limit) pos++;
                removed = slots.size() - pos;
                while (slots.size() > pos) void'(slots.pop_back());
                push_word(psq_pkg::KIND_ACK, 0, 0, 0, 5'(removed), 1'b1);
            end
            psq_pkg::CMD_CLR_ALL: begin
                removed = slots.size();
                slots.delete();
                push_word(psq_pkg::KIND_ACK, 0, 0, 0, 5'(removed), 1'b1);
            end
            psq_pkg::CMD_PURGE: begin
                foreach (slots[i])
                    if (!(slots[i].notice && slots[i].dest == c.dest_key))
                        kept.push_back(slots[i]);
                removed = slots.size() - kept.size();
                slots = kept;
                push_word(psq_pkg::KIND_ACK, 0, 0, 0, 5'(removed), 1'b1);
            end
            default: push_word(psq_pkg::KIND_ACK, 0, 0, 0, 0, 1'b1);
        endcase
    endfunction

    function void check_word(psq_pkg::t_out_word got);
        psq_pkg::t_out_word exp;
        if (pending_words.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            fail_count++;
            return;
        end
        exp = pending_words.pop_front();
        if (got.kind !== exp.kind) begin
            $error("kind: expected %0d, got %0d", exp.kind, got.kind);
            fail_count++;
        end
        if (got.sent_handle !== exp.sent_handle) begin
            $error("sent_handle: expected %0d, got %0d", exp.sent_handle, got.sent_handle);
            fail_count++;
        end
        if (got.wait_seconds !== exp.wait_seconds) begin
            $error("wait_seconds: expected %0d, got %0d", exp.wait_seconds,
                   got.wait_seconds);
            fail_count++;
        end
        if (got.queue_full !== exp.queue_full) begin
            $error("queue_full: expected %0d, got %0d", exp.queue_full, got.queue_full);
            fail_count++;
        end
        if (got.removed_count !== exp.removed_count) begin
            $error("removed_count: expected %0d, got %0d", exp.removed_count,
                   got.removed_count);
            fail_count++;
        end
        if (got.last_of_run !== exp.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", exp.last_of_run,
                   got.last_of_run);
            fail_count++;
        end
    endfunction
endclass

// ----- bench/tb_top.sv -----
// top of the send queue testbench: stimulus, register writes, result checking
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [psq_pkg::APB_AW-1:0] paddr = '0;
    logic [psq_pkg::APB_DW-1:0] pwdata = '0;
    logic [psq_pkg::APB_DW-1:0] prdata;
    logic pready;

    psq_in_if cmd_ch();
    psq_out_if rsp_ch();

    priority_send_queue_with_credit_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(cmd_ch.sink), .o_rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    psq_scoreboard sb = new();

    // idle percentages; zero gives a stretch with no gaps at all
    int send_idle_pct = 36;
    int recv_idle_pct = 36;
    bit recv_hold = 1'b0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    // result side: ready toggles at the falling edge, words taken at the rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n || recv_hold) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_word(rsp_ch.data);
        end
    end

    // watchdog: counts cycles with no handshake on either channel and no register access
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("priority_send_queue_with_credit_unit test failed");
            $finish;
        end
    end

    // register write through setup and access cycles; only called while idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= psq_pkg::APB_AW'(idx) << 2;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            psq_pkg::REG_OFFSET: sb.cfg.priority_offset = value[10:0];
            psq_pkg::REG_LOW_LIMIT: sb.cfg.low_priority_limit = value[11:0];
            psq_pkg::REG_CAP: sb.cfg.credit_cap = value[3:0];
            psq_pkg::REG_COST: sb.cfg.credit_cost = value[3:0];
            default: sb.cfg.idle_wait_seconds = value[7:0];
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // offer one command word, with a random gap ahead of it; valid stays up
    // for a back-to-back word and drops in a gap
    task automatic send_cmd(input psq_pkg::t_in_word c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(c);
        @(negedge i_clk);
    endtask

    // wait until every expected word is in, then let the block settle
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic psq_pkg::t_in_word make_cmd(logic [2:0] op, logic [10:0] prio,
                                                   logic [15:0] handle, logic [15:0] dest,
                                                   logic notice, logic [7:0] elapsed);
        psq_pkg::t_in_word c;
        c.command = op;
        c.base_priority = prio;
        c.payload_handle = handle;
        c.dest_key = dest;
        c.is_notice = notice;
        c.elapsed_seconds = elapsed;
        return c;
    endfunction

    // mostly enqueues and drains, with a few clears and purges on a small key set
    function automatic psq_pkg::t_in_word random_cmd();
        psq_pkg::t_in_word c;
        int pick;
        c = psq_pkg::t_in_word'($bits(psq_pkg::t_in_word)'({$urandom, $urandom}));
        pick = $urandom_range(99);
        if (pick < 50) c.command = psq_pkg::CMD_ENQ;
        else if (pick < 78) c.command = psq_pkg::CMD_DRAIN;
        else if (pick < 85) c.command = psq_pkg::CMD_CLR_LOW;
        else if (pick < 89) c.command = psq_pkg::CMD_CLR_ALL;
        else if (pick < 96) c.command = psq_pkg::CMD_PURGE;
        else c.command = 3'($urandom_range(7, 5));
        if ($urandom_range(3) != 0) c.dest_key = 16'($urandom_range(3));
        if ($urandom_range(1)) c.elapsed_seconds = 8'($urandom_range(6));
        return c;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) send_cmd(random_cmd());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty drain, extremes of fields, equal priority order, full queue
        send_cmd(make_cmd(psq_pkg::CMD_DRAIN, 0, 0, 0, 0, 8'd255));
        send_cmd(make_cmd(psq_pkg::CMD_ENQ, 11'd2047, 16'hffff, 16'hffff, 1'b1, 8'hff));
        send_cmd(make_cmd(psq_pkg::CMD_ENQ, 11'd0, 16'h0000, 16'h0000, 1'b0, 8'h00));
        send_cmd(make_cmd(psq_pkg::CMD_ENQ, 11'd300, 16'h0011, 16'h0005, 1'b1, 0));
        send_cmd(make_cmd(psq_pkg::CMD_ENQ, 11'd300, 16'h0022, 16'h0005, 1'b0, 0));
        send_cmd(make_cmd(psq_pkg::CMD_ENQ, 11'd300, 16'h0033, 16'h0005, 1'b1, 0));
        send_cmd(make_cmd(psq_pkg::CMD_PURGE, 0, 0, 16'h0005, 0, 0));
        send_cmd(make_cmd(psq_pkg::CMD_CLR_LOW, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(psq_pkg::CMD_DRAIN, 0, 0, 0, 0, 8'd0));
        send_cmd(make_cmd(psq_pkg::CMD_DRAIN, 0, 0, 0, 0, 8'd255));
        send_cmd(make_cmd(3'd5, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(3'd7, 11'h7ff, 16'hffff, 16'hffff, 1'b1, 8'hff));
        for (int k = 0; k < 17; k++)
            send_cmd(make_cmd(psq_pkg::CMD_ENQ, 11'($urandom_range(2047)), 16'(k), 16'(k),
                              0, 0));
        send_cmd(make_cmd(psq_pkg::CMD_CLR_ALL, 0, 0, 0, 0, 0));
        wait_drained();

        // extremes of every register, then fill to stall: receiver holds off
        write_reg(psq_pkg::REG_OFFSET, 32'd2047);
        write_reg(psq_pkg::REG_LOW_LIMIT, 32'd4095);
        write_reg(psq_pkg::REG_CAP, 32'd15);
        write_reg(psq_pkg::REG_COST, 32'd1);
        write_reg(psq_pkg::REG_IDLE_WAIT, 32'd255);
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            random_phase(30);
        join
        // sender pauses until everything is out
        wait_drained();

        write_reg(psq_pkg::REG_OFFSET, 32'd0);
        write_reg(psq_pkg::REG_LOW_LIMIT, 32'd0);
        write_reg(psq_pkg::REG_CAP, 32'd1);
        write_reg(psq_pkg::REG_COST, 32'd15);
        write_reg(psq_pkg::REG_IDLE_WAIT, 32'd1);
        // no idling on either side for this stretch
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(40);
        wait_drained();
        send_idle_pct = 36;
        recv_idle_pct = 36;

        write_reg(psq_pkg::REG_OFFSET, 32'($urandom_range(2047)));
        write_reg(psq_pkg::REG_LOW_LIMIT, 32'($urandom_range(4095)));
        write_reg(psq_pkg::REG_CAP, 32'($urandom_range(15, 1)));
        write_reg(psq_pkg::REG_COST, 32'($urandom_range(15, 1)));
        write_reg(psq_pkg::REG_IDLE_WAIT, 32'($urandom_range(255, 1)));
        random_phase(70);
        wait_drained();

        if (sb.fail_count == 0 && sb.pending_words.size() == 0) begin
            $display("priority_send_queue_with_credit_unit test passed");
        end else begin
            $display("priority_send_queue_with_credit_unit test failed");
        end
        $finish;
    end
endmodule
